// File: design/sobel_edge_magnitude_defines.svh
// assertion macros shared by the sobel edge magnitude checkers
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SEM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sem_pkg.sv
// types and constants of the sobel edge magnitude block
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CMP_W     = ((COL_W > 11) ? COL_W : 11) + 1;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int PIX_W     = 24;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [2:0]       t_row;
    typedef t_row [2:0]       t_nb;

    typedef struct packed {
        t_nb         nb;
        logic [11:0] row;
        logic [9:0]  col;
        logic        frame_done;
        logic        run_last;
    } t_job;
endpackage
`default_nettype wire

// File: design/sobel_edge_magnitude.sv
// front: accepts a pixel in F_IDLE, reads and writes the line store in F_READ, then issues
// one job per pending result in F_EMIT (stalling while the 4-job queue is full) before the next pixel
// the back end takes one job at a time: gradient, square, 8 root steps, output hold
// frame start after reset or any register write: row 0, column 0, window cleared
// synchronous active-low reset clears control state; line store contents stay unknown
`default_nettype none
module sobel_edge_magnitude (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    // pixel input channel
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [7:0]  i_pix_red,
    input  wire logic [7:0]  i_pix_green,
    input  wire logic [7:0]  i_pix_blue,
    // edge result channel
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [7:0]  o_edge_red,
    output      logic [7:0]  o_edge_green,
    output      logic [7:0]  o_edge_blue,
    output      logic [11:0] o_out_row,
    output      logic [9:0]  o_out_col,
    output      logic        o_frame_done,
    output      logic        o_run_last
);
    import sem_pkg::*;

    // front to queue
    logic f_valid;
    logic f_ready;
    t_job f_job;
    // queue to back
    logic q_valid;
    logic q_ready;
    t_job q_job;

    // front: line store read-modify-write, window shift, one job per result
    sem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pix_red   (i_pix_red),
        .i_pix_green (i_pix_green),
        .i_pix_blue  (i_pix_blue),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    // queue absorbs row-end bursts of up to four jobs
    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    // back: per-channel gradient magnitude, result held until the transaction completes
    sem_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .o_job_ready  (q_ready),
        .i_job        (q_job),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_edge_red   (o_edge_red),
        .o_edge_green (o_edge_green),
        .o_edge_blue  (o_edge_blue),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_done (o_frame_done),
        .o_run_last   (o_run_last)
    );
endmodule
`default_nettype wire

// File: design/sem_ram.sv
// generic single-write, registered-read ram
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: design/sem_front.sv
// front end: pixel intake, line stores, window and job issue
`default_nettype none
module sem_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output      logic          o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [12:0]   i_cfg_data,
    input  wire logic          i_valid,
    output      logic          o_ready,
    input  wire logic [7:0]    i_pix_red,
    input  wire logic [7:0]    i_pix_green,
    input  wire logic [7:0]    i_pix_blue,
    output      logic          o_job_valid,
    input  wire logic          i_job_ready,
    output      sem_pkg::t_job o_job
);
    import sem_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_EMIT = 3'b100
    } t_fstate;

    t_fstate          r_state;
    logic [10:0]      r_width;
    logic [12:0]      r_height;
    logic [11:0]      r_row;
    logic [COL_W-1:0] r_col;
    t_pix             r_pix;
    t_nb              r_win;
    logic [3:0]       r_mask;
    logic             r_rowend;
    logic             r_lastrow;

    logic [47:0]      ram_rdata;
    logic [CMP_W-1:0] w_eff;
    logic [12:0]      h_eff;
    logic [CMP_W-1:0] c_ext;
    logic             row_end;
    logic             last_row;
    t_pix             up;
    t_pix             lo;
    t_nb              win_new;
    logic [3:0]       mask_new;
    logic [3:0]       sel;
    logic [3:0]       rest;
    logic             accept;
    logic             cfg_wr;
    logic [CMP_W-1:0] c_m1;
    logic [11:0]      r_m1;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_ready     = (r_state == F_IDLE);
    assign accept      = i_valid && o_ready;

    sem_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_state == F_READ),
        .i_waddr (r_col),
        .i_wdata ({ram_rdata[23:0], r_pix}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        // saturated frame size
        if (r_width == 11'd0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(r_width);
        end
        if (r_height == 13'd0) begin
            h_eff = 13'd1;
        end else if (r_height > 13'd4096) begin
            h_eff = 13'd4096;
        end else begin
            h_eff = r_height;
        end
        c_ext    = CMP_W'(r_col);
        c_m1     = c_ext - CMP_W'(1);
        r_m1     = r_row - 12'd1;
        row_end  = (c_ext + CMP_W'(1)) >= w_eff;
        last_row = ({1'b0, r_row} + 13'd1) >= h_eff;

        // rows above the frame read as zero
        up = (r_row >= 12'd2) ? ram_rdata[47:24] : '0;
        lo = (r_row >= 12'd1) ? ram_rdata[23:0] : '0;
        // at a row start the two left columns are cleared before the shift,
        // so the middle column still takes the old right column
        for (int k = 0; k < 3; k++) begin
            win_new[k][0] = (r_col == '0) ? '0 : r_win[k][1];
            win_new[k][1] = r_win[k][2];
        end
        win_new[0][2] = up;
        win_new[1][2] = lo;
        win_new[2][2] = r_pix;

        mask_new[0] = (r_row != '0) && (r_col != '0);
        mask_new[1] = (r_row != '0) && row_end;
        mask_new[2] = last_row && (r_col != '0);
        mask_new[3] = last_row && row_end;

        // lowest pending result goes first
        sel = r_mask & (~r_mask + 4'd1);
        rest = r_mask & ~sel;

        o_job            = '0;
        o_job.run_last   = (rest == 4'd0);
        o_job.frame_done = (rest == 4'd0) && r_rowend && r_lastrow;
        unique case (sel)
            4'b0001: begin
                o_job.nb  = r_win;
                o_job.row = r_m1;
                o_job.col = c_m1[9:0];
            end
            4'b0010: begin
                for (int k = 0; k < 3; k++) begin
                    o_job.nb[k][0] = r_win[k][1];
                    o_job.nb[k][1] = r_win[k][2];
                end
                o_job.row = r_m1;
                o_job.col = c_ext[9:0];
            end
            4'b0100: begin
                o_job.nb[0] = r_win[1];
                o_job.nb[1] = r_win[2];
                o_job.row   = r_row;
                o_job.col   = c_m1[9:0];
            end
            4'b1000: begin
                for (int k = 0; k < 2; k++) begin
                    o_job.nb[k][0] = r_win[k+1][1];
                    o_job.nb[k][1] = r_win[k+1][2];
                end
                o_job.row = r_row;
                o_job.col = c_ext[9:0];
            end
            default: begin
                o_job.nb = '0;
            end
        endcase
    end

    assign o_job_valid = (r_state == F_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_width  <= 11'd640;
            r_height <= 13'd480;
            r_row    <= '0;
            r_col    <= '0;
            r_mask   <= '0;
            r_win    <= '0;
        end else if (cfg_wr) begin
            // any register write restarts the frame
            if (i_cfg_index == REG_WIDTH) begin
                r_width <= i_cfg_data[10:0];
            end else if (i_cfg_index == REG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            r_state <= F_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_mask  <= '0;
            r_win   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_pix   <= {i_pix_red, i_pix_green, i_pix_blue};
                        r_state <= F_READ;
                    end
                end
                F_READ: begin
                    r_win     <= win_new;
                    r_mask    <= mask_new;
                    r_rowend  <= row_end;
                    r_lastrow <= last_row;
                    if (mask_new == 4'd0) begin
                        r_state <= F_IDLE;
                        if (row_end) begin
                            r_col <= '0;
                            r_row <= last_row ? '0 : r_row + 12'd1;
                        end else begin
                            r_col <= r_col + COL_W'(1);
                        end
                    end else begin
                        r_state <= F_EMIT;
                    end
                end
                F_EMIT: begin
                    if (i_job_ready) begin
                        r_mask <= rest;
                        if (rest == 4'd0) begin
                            r_state <= F_IDLE;
                            if (r_rowend) begin
                                r_col <= '0;
                                r_row <= r_lastrow ? '0 : r_row + 12'd1;
                            end else begin
                                r_col <= r_col + COL_W'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/sem_queue.sv
// short job queue between front and back
`default_nettype none
module sem_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_ready,
    input  wire sem_pkg::t_job i_job,
    output      logic          o_valid,
    input  wire logic          i_ready,
    output      sem_pkg::t_job o_job
);
    import sem_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/sem_back.sv
// back end: gradients, squared sum and rounded square root per channel
`default_nettype none
module sem_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output      logic          o_job_ready,
    input  wire sem_pkg::t_job i_job,
    output      logic          o_valid,
    input  wire logic          i_ready,
    output      logic [7:0]    o_edge_red,
    output      logic [7:0]    o_edge_green,
    output      logic [7:0]    o_edge_blue,
    output      logic [11:0]   o_out_row,
    output      logic [9:0]    o_out_col,
    output      logic          o_frame_done,
    output      logic          o_run_last
);
    import sem_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_SQR  = 4'b0010,
        B_ROOT = 4'b0100,
        B_OUT  = 4'b1000
    } t_bstate;

    t_bstate            r_state;
    logic [2:0]         r_bit;
    logic [11:0]        r_row;
    logic [9:0]         r_col;
    logic               r_fd;
    logic               r_rl;
    logic signed [10:0] r_gx [3];
    logic signed [10:0] r_gy [3];
    logic [20:0]        r_s  [3];
    logic [7:0]         r_m  [3];
    logic [7:0]         r_edge [3];

    logic signed [10:0] gx [3];
    logic signed [10:0] gy [3];
    logic [20:0]        s_sum [3];
    logic [7:0]         m_next [3];
    logic [7:0]         edge_val [3];

    assign o_job_ready = (r_state == B_IDLE);
    assign o_valid     = (r_state == B_OUT);

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        localparam int SH = 16 - 8 * ch;
        logic [9:0]         px_pos;
        logic [9:0]         px_neg;
        logic [9:0]         py_pos;
        logic [9:0]         py_neg;
        logic signed [21:0] sqx;
        logic signed [21:0] sqy;
        logic [7:0]         trial;
        logic [16:0]        prod;

        always_comb begin
            px_pos = 10'(i_job.nb[0][2][SH+:8]) + {1'b0, i_job.nb[1][2][SH+:8], 1'b0}
                   + 10'(i_job.nb[2][2][SH+:8]);
            px_neg = 10'(i_job.nb[0][0][SH+:8]) + {1'b0, i_job.nb[1][0][SH+:8], 1'b0}
                   + 10'(i_job.nb[2][0][SH+:8]);
            py_pos = 10'(i_job.nb[2][0][SH+:8]) + {1'b0, i_job.nb[2][1][SH+:8], 1'b0}
                   + 10'(i_job.nb[2][2][SH+:8]);
            py_neg = 10'(i_job.nb[0][0][SH+:8]) + {1'b0, i_job.nb[0][1][SH+:8], 1'b0}
                   + 10'(i_job.nb[0][2][SH+:8]);
            gx[ch] = $signed({1'b0, px_pos}) - $signed({1'b0, px_neg});
            gy[ch] = $signed({1'b0, py_pos}) - $signed({1'b0, py_neg});

            sqx       = r_gx[ch] * r_gx[ch];
            sqy       = r_gy[ch] * r_gy[ch];
            s_sum[ch] = sqx[20:0] + sqy[20:0];

            // largest m with m*(m+1) < s, one bit per cycle
            trial = r_m[ch] | (8'd1 << r_bit);
            prod  = 17'(trial) * (17'(trial) + 17'd1);
            m_next[ch] = ({4'd0, prod} < r_s[ch]) ? trial : r_m[ch];

            if (r_s[ch] == '0) begin
                edge_val[ch] = 8'd0;
            end else if (m_next[ch] == 8'd255) begin
                edge_val[ch] = 8'd255;
            end else begin
                edge_val[ch] = m_next[ch] + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        for (int ch = 0; ch < 3; ch++) begin
                            r_gx[ch] <= gx[ch];
                            r_gy[ch] <= gy[ch];
                        end
                        r_row   <= i_job.row;
                        r_col   <= i_job.col;
                        r_fd    <= i_job.frame_done;
                        r_rl    <= i_job.run_last;
                        r_state <= B_SQR;
                    end
                end
                B_SQR: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_s[ch] <= s_sum[ch];
                        r_m[ch] <= '0;
                    end
                    r_bit   <= 3'd7;
                    r_state <= B_ROOT;
                end
                B_ROOT: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_m[ch] <= m_next[ch];
                    end
                    r_bit <= r_bit - 3'd1;
                    if (r_bit == 3'd0) begin
                        for (int ch = 0; ch < 3; ch++) begin
                            r_edge[ch] <= edge_val[ch];
                        end
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (i_ready) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_edge_red   = r_edge[0];
    assign o_edge_green = r_edge[1];
    assign o_edge_blue  = r_edge[2];
    assign o_out_row    = r_row;
    assign o_out_col    = r_col;
    assign o_frame_done = r_fd;
    assign o_run_last   = r_rl;
endmodule
`default_nettype wire

// File: design/sem_checker.sv
// port-level checker for the sobel edge magnitude block, with its bind
`include "sobel_edge_magnitude_defines.svh"
`default_nettype none
module sem_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_edge_red,
    input wire logic [7:0]  o_edge_green,
    input wire logic [7:0]  o_edge_blue,
    input wire logic [11:0] o_out_row,
    input wire logic [9:0]  o_out_col,
    input wire logic        o_frame_done,
    input wire logic        o_run_last
);
    // frame end always closes the run of its pixel
    `SEM_ASSERT_SAME(a_done_last, i_clk, i_rst_n, o_valid && o_frame_done, o_run_last, "frame_done without run_last")
    // an accepted pixel keeps the front busy while the line store is read
    `SEM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready && !i_cfg_valid, !o_ready, "input ready right after a transaction")
    // a stalled result holds
    `SEM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_edge_red) && $stable(o_out_col) && $stable(o_out_row), "stalled result changed")
    // configuration port never back-pressures
    `SEM_ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "configuration write stalled")
endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);
`default_nettype wire
